FILE: design/stb_pkg.sv
package stb_pkg;

    localparam int unsigned NUM_TIMERS = 16;
    localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned TICKS_W = 32;
    localparam int unsigned IN_DATA_W = 72;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_TICK    = 2'd1,
        OP_SERVICE = 2'd2
    } op_t;

    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [SLOT_W-1:0]  slot;
        logic [TICKS_W-1:0] interval;
        logic [TICKS_W-1:0] period;
        logic               rt;
    } cmd_t;

endpackage

FILE: design/stb_front.sv
module stb_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [1:0]                        s_axis_tuser,  // operation
    // timer_slot, interval_ticks, period_ticks, is_realtime, zero fill
    input  logic [stb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              cmd_valid,
    output stb_pkg::cmd_t                     cmd,
    input  logic                              cmd_pop
);
    import stb_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              keep;
    logic              push;
    cmd_t              in_cmd;

    // classify: drop unused codes and starts outside the bank
    always_comb
    begin
        in_cmd.slot     = s_axis_tdata[SLOT_W-1:0];
        in_cmd.interval = s_axis_tdata[SLOT_W +: TICKS_W];
        in_cmd.period   = s_axis_tdata[SLOT_W+TICKS_W +: TICKS_W];
        in_cmd.rt       = s_axis_tdata[SLOT_W+2*TICKS_W];
        in_cmd.op       = OP_START;
        keep            = 1'b0;
        case (s_axis_tuser)
            OP_START:
            begin
                in_cmd.op = OP_START;
                keep      = (32'(in_cmd.slot) < NUM_TIMERS);
            end
            OP_TICK:
            begin
                in_cmd.op = OP_TICK;
                keep      = 1'b1;
            end
            OP_SERVICE:
            begin
                in_cmd.op = OP_SERVICE;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign cmd_valid     = (cnt_reg != '0);
    assign cmd           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: design/stb_back.sv
module stb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  stb_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic                           m_axis_tuser,  // kind
    output logic                           m_axis_tlast,  // last
    // timer_index, nrt_notify, zero fill
    output logic [stb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import stb_pkg::*;

    logic [TICKS_W-1:0]    delay_reg  [NUM_TIMERS];
    logic [TICKS_W-1:0]    period_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [NUM_TIMERS-1:0] armed_next;
    logic [NUM_TIMERS-1:0] rt_reg;
    logic [NUM_TIMERS-1:0] rt_next;

    state_t             state_reg;
    state_t             state_next;
    op_t                op_reg;
    op_t                op_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               notify_reg;
    logic               notify_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_kind_reg;
    logic [SLOT_W-1:0]  out_index_reg;
    logic               out_notify_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               emit;
    logic               emit_kind;
    logic [SLOT_W-1:0]  emit_index;
    logic               emit_notify;
    logic               dly_wr;
    logic [IDX_W-1:0]   dly_addr;
    logic [TICKS_W-1:0] dly_data;
    logic               per_wr;
    logic               slot_fire;
    logic               slot_notify;
    logic [TICKS_W-1:0] cur_cnt;
    logic [TICKS_W-1:0] cur_per;
    logic               cur_armed;
    logic               cur_rt;
    logic [IDX_W-1:0]   start_idx;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign start_idx = IDX_W'(cmd.slot);
    assign cur_cnt   = delay_reg[idx_reg];
    assign cur_per   = period_reg[idx_reg];
    assign cur_armed = armed_reg[idx_reg];
    assign cur_rt    = rt_reg[idx_reg];

    // one slot per cycle while the output is free: due test and notify test
    always_comb
    begin
        slot_fire   = 1'b0;
        slot_notify = 1'b0;
        if (op_reg == OP_TICK)
        begin
            if (cur_armed && cur_rt)
            begin
                slot_fire = (cur_cnt <= TICKS_W'(1));
            end
            else if (cur_armed)
            begin
                slot_notify = (cur_cnt == TICKS_W'(1));
            end
        end
        else
        begin
            slot_fire = cur_armed && !cur_rt && (cur_cnt == '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.op != OP_START)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (out_free && idx_reg == IDX_W'(NUM_TIMERS - 1))
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop     = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_EXPIRY;
        emit_index  = SLOT_W'(idx_reg);
        emit_notify = 1'b0;
        dly_wr      = 1'b0;
        dly_addr    = idx_reg;
        dly_data    = cmd.interval;
        per_wr      = 1'b0;
        armed_next  = armed_reg;
        rt_next     = rt_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        notify_next = notify_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == OP_START)
                    begin
                        dly_wr              = 1'b1;
                        per_wr              = 1'b1;
                        dly_addr            = start_idx;
                        armed_next[start_idx] = 1'b1;
                        rt_next[start_idx]    = cmd.rt;
                    end
                    else
                    begin
                        op_next     = cmd.op;
                        idx_next    = '0;
                        notify_next = 1'b0;
                    end
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (slot_fire)
                    begin
                        emit = 1'b1;
                        if (cur_per != '0)
                        begin
                            dly_wr   = 1'b1;
                            dly_data = cur_per;
                        end
                        else
                        begin
                            armed_next[idx_reg] = 1'b0;
                        end
                    end
                    else if (op_reg == OP_TICK && cur_armed && cur_cnt != '0)
                    begin
                        dly_wr   = 1'b1;
                        dly_data = cur_cnt - 1'b1;
                    end
                    if (slot_notify)
                    begin
                        notify_next = 1'b1;
                    end
                end
            end
            ST_CLOSE:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_CLOSE;
                    emit_index  = '0;
                    emit_notify = notify_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TICK;
            idx_reg       <= '0;
            notify_reg    <= 1'b0;
            armed_reg     <= '0;
            rt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            notify_reg    <= notify_next;
            armed_reg     <= armed_next;
            rt_reg        <= rt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dly_wr)
        begin
            delay_reg[dly_addr] <= dly_data;
        end
        if (per_wr)
        begin
            period_reg[start_idx] <= cmd.period;
        end
        if (emit)
        begin
            out_kind_reg   <= emit_kind;
            out_index_reg  <= emit_index;
            out_notify_reg <= emit_notify;
            out_last_reg   <= (emit_kind == KIND_CLOSE);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - SLOT_W - 1){1'b0}}, out_notify_reg, out_index_reg};

endmodule

FILE: design/software_timer_bank.sv
// software timer bank: sixteen one-shot or periodic slots, real-time or deferred
// input channel s_axis: tuser carries the operation (start, tick, service),
// tdata carries slot, initial delay, reload period and the real-time flag
// a start passes through the command queue and gives no result
// a tick or service pass walks every slot, one slot per cycle while the output
// is free, and then gives the item that closes the pass
// output channel m_axis: tuser is the kind (expiry or end of pass), tdata holds
// the slot index and the deferred-due notify, tlast marks the closing item
// expiries come out in slot order
// a two-entry command queue keeps taking items while a pass runs
// when the receiver stalls, the walk holds on its current slot and the
// finished result waits in the output register; the queue fills and then
// tready drops
// reset disarms all slots and empties the queue and the output register;
// delay and period storage is written on each start and needs no clearing
module software_timer_bank (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [1:0]                        s_axis_tuser,  // operation
    // timer_slot, interval_ticks, period_ticks, is_realtime, zero fill
    input  logic [stb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic                              m_axis_tuser,  // kind
    output logic                              m_axis_tlast,  // last
    // timer_index, nrt_notify, zero fill
    output logic [stb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import stb_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    stb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    stb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTH
    a_pop_needs_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_close_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_CLOSE) == m_axis_tlast)
        else $error("tlast does not match closing item");

    a_expiry_no_notify : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_EXPIRY) |-> !m_axis_tdata[SLOT_W])
        else $error("notify set on an expiry item");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 345;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]         op;
        logic [SLOT_W-1:0]  slot;
        logic [TICKS_W-1:0] interval;
        logic [TICKS_W-1:0] period;
        logic               rt;
        bit                 typed;
        bit                 typed_fires;
        logic [SLOT_W-1:0]  typed_index;
        logic               typed_notify;
    } timer_cmd_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] index;
        logic              notify;
        logic              last;
    } timer_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [1:0]            s_axis_tuser;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bit                 timer_armed [NUM_TIMERS];
    bit                 timer_rt [NUM_TIMERS];
    logic [TICKS_W-1:0] timer_left [NUM_TIMERS];
    logic [TICKS_W-1:0] timer_reload [NUM_TIMERS];

    timer_event_t expected_events [$];
    timer_cmd_t   directed_cmds [$];
    int           events_seen;
    int           mismatches;
    int           tx_calm;
    int           rx_calm;
    bit           long_hold;

    software_timer_bank i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // random gap with occasional calm stretches of back-to-back items
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [TICKS_W-1:0] draw_ticks();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 6);
    endfunction

    function automatic timer_cmd_t mk_cmd(logic [1:0] op, logic [SLOT_W-1:0] slot,
                                          logic [TICKS_W-1:0] interval,
                                          logic [TICKS_W-1:0] period, logic rt,
                                          bit typed, bit fires,
                                          logic [SLOT_W-1:0] index, logic notify);
        timer_cmd_t c;
        c.op           = op;
        c.slot         = slot;
        c.interval     = interval;
        c.period       = period;
        c.rt           = rt;
        c.typed        = typed;
        c.typed_fires  = fires;
        c.typed_index  = index;
        c.typed_notify = notify;
        return c;
    endfunction

    function automatic void fire_timer(int i);
        if (timer_reload[i] != '0)
            timer_left[i] = timer_reload[i];
        else
            timer_armed[i] = 1'b0;
    endfunction

    // advances the timer bank by one item and returns the events it causes
    function automatic void run_timer_bank(timer_cmd_t c, ref timer_event_t evs [$]);
        timer_event_t ev;
        bit           notify;
        evs    = {};
        notify = 1'b0;
        if (c.op == OP_START)
        begin
            timer_left[c.slot]   = c.interval;
            timer_reload[c.slot] = c.period;
            timer_rt[c.slot]     = c.rt;
            timer_armed[c.slot]  = 1'b1;
        end
        else if (c.op == OP_TICK || c.op == OP_SERVICE)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (!timer_armed[i])
                    continue;
                if (c.op == OP_TICK && timer_rt[i])
                begin
                    if (timer_left[i] <= 1)
                    begin
                        ev = '{KIND_EXPIRY, i[SLOT_W-1:0], 1'b0, 1'b0};
                        evs.push_back(ev);
                        fire_timer(i);
                    end
                    else
                        timer_left[i]--;
                end
                else if (c.op == OP_TICK && timer_left[i] != '0)
                begin
                    timer_left[i]--;
                    if (timer_left[i] == '0)
                        notify = 1'b1;
                end
                else if (c.op == OP_SERVICE && !timer_rt[i] && timer_left[i] == '0)
                begin
                    ev = '{KIND_EXPIRY, i[SLOT_W-1:0], 1'b0, 1'b0};
                    evs.push_back(ev);
                    fire_timer(i);
                end
            end
            ev = '{KIND_CLOSE, '0, notify, 1'b1};
            evs.push_back(ev);
        end
    endfunction

    task automatic send_cmd(timer_cmd_t c);
        timer_event_t evs [$];
        timer_event_t ev;
        int           gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = c.op;
        s_axis_tdata  = {3'b000, c.rt, c.period, c.interval, c.slot};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        run_timer_bank(c, evs);
        if (c.typed && c.op != OP_START)
        begin
            evs = {};
            if (c.typed_fires)
            begin
                ev = '{KIND_EXPIRY, c.typed_index, 1'b0, 1'b0};
                evs.push_back(ev);
            end
            ev = '{KIND_CLOSE, '0, c.typed_notify, 1'b1};
            evs.push_back(ev);
        end
        foreach (evs[k])
            expected_events.push_back(evs[k]);
        @(negedge clk);
    endtask

    task automatic check_event();
        timer_event_t got;
        timer_event_t want;
        got.kind   = m_axis_tuser;
        got.index  = m_axis_tdata[SLOT_W-1:0];
        got.notify = m_axis_tdata[SLOT_W];
        got.last   = m_axis_tlast;
        events_seen++;
        if (expected_events.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected item: kind %0d index %0d notify %0d last %0d",
                         got.kind, got.index, got.notify, got.last);
        end
        else
        begin
            want = expected_events.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("mismatch: expected kind %0d index %0d notify %0d last %0d, ",
                           want.kind, want.index, want.notify, want.last);
                    $display("got kind %0d index %0d notify %0d last %0d",
                             got.kind, got.index, got.notify, got.last);
                end
            end
        end
    endtask

    // receiver
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            while (long_hold)
            begin
                m_axis_tready = 1'b0;
                @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            check_event();
            @(negedge clk);
        end
    end

    // long receiver hold-off so the command queue fills and input stalls
    initial
    begin
        long_hold = 1'b0;
        wait (events_seen >= 60);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        timer_cmd_t c;
        int         pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        events_seen   = 0;
        mismatches    = 0;
        tx_calm       = 0;
        rx_calm       = 0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            timer_armed[i]  = 1'b0;
            timer_rt[i]     = 1'b0;
            timer_left[i]   = '0;
            timer_reload[i] = '0;
        end

        // idle bank after reset
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_SERVICE, 0, 0, 0, 0, 1, 0, 0, 0));
        // unused operation with every field bit set
        directed_cmds.push_back(mk_cmd(OP_UNUSED, 15, '1, '1, 1, 0, 0, 0, 0));
        // real-time one-shot with zero delay fires on first tick, then freed
        directed_cmds.push_back(mk_cmd(OP_START, 15, 0, 0, 1, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 1, 1, 15, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 1, 0, 0, 0));
        // deferred zero delay: due at service without tick or notify
        directed_cmds.push_back(mk_cmd(OP_START, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 1, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_SERVICE, 0, 0, 0, 0, 1, 1, 0, 0));
        // deferred periodic: notify on tick, fires at service
        directed_cmds.push_back(mk_cmd(OP_START, 3, 1, 2, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 1, 0, 0, 1));
        directed_cmds.push_back(mk_cmd(OP_SERVICE, 0, 0, 0, 0, 1, 1, 3, 0));
        // real-time periodic with period one
        directed_cmds.push_back(mk_cmd(OP_START, 5, 1, 1, 1, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 1, 1, 5, 0));
        // overwrite of an armed slot, class changes
        directed_cmds.push_back(mk_cmd(OP_START, 7, '1, '1, 1, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_START, 7, 2, 0, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_START, 9, 2, 3, 1, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0));
        // full-range delays and periods
        directed_cmds.push_back(mk_cmd(OP_START, 10, '1, '1, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_START, 11, 0, '1, 1, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_cmds.push_back(mk_cmd(OP_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_cmds[k])
            send_cmd(directed_cmds[k]);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            pick       = $urandom_range(0, 99);
            c          = mk_cmd(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0);
            c.slot     = $urandom_range(0, NUM_TIMERS - 1);
            c.rt       = $urandom_range(0, 1);
            c.interval = draw_ticks();
            c.period   = draw_ticks();
            if (pick < 45)
                c.op = OP_START;
            else if (pick < 75)
                c.op = OP_TICK;
            else if (pick < 95)
                c.op = OP_SERVICE;
            send_cmd(c);
        end
        s_axis_tvalid = 1'b0;

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4 * NUM_TIMERS) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
